FILE: sv/crcpd_pkg.sv
// Shared types, constants and the CRC byte update for the framed packet decoder.
package crcpd_pkg;

   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Header byte positions within a frame
   localparam logic [8:0] POS_ID       = 9'd2;
   localparam logic [8:0] POS_TS_FIRST = 9'd3;
   localparam logic [8:0] POS_TS_LAST  = 9'd6;
   localparam logic [8:0] POS_LENGTH   = 9'd7;
   localparam logic [8:0] HEADER_BYTES = 9'd8;

   // One result item as it sits in the output queue
   typedef struct packed {
      logic        is_summary;
      logic        crc_ok;
      logic [7:0]  payload_length;
      logic [31:0] frame_timestamp;
      logic [7:0]  frame_id;
      logic [7:0]  payload_index;
      logic [7:0]  payload_byte;
   } result_type;

   // MSB-first CRC-16 update over one byte, no reflection
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/crc_framed_packet_decoder.sv
// Top level: framed packet decoder with CRC-16 check, one frame byte per request.
//
// Request channel (req_): one frame byte in req_tdata, req_tuser high on byte 0 of
// a frame. A start always restarts decoding; bytes outside a frame are dropped.
// Response channel (rsp_): rsp_tuser low for a payload byte result, high for the
// end-of-frame summary that carries crc_ok. Header bytes and the CRC high byte
// give no response.
// Throughput: one request per cycle while the queue has room, set by the
// combinational CRC byte update in the decode state loop. Each response is
// registered in the output queue, behind any response still waiting there.
// Stall: responses go into a two-entry queue; req_tready drops only when both
// entries are occupied, so a request is still taken while one response waits.
// Reset (synchronous): decoder goes idle, CRC returns to 0xFFFF, held header
// fields clear and the queue empties.
module crc_framed_packet_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_id,
   // [55:24] frame_timestamp, [63:56] payload_length, [64] crc_ok, [71:65] zero
   output logic [71:0] rsp_tdata,
   output logic        rsp_tuser    // [0] is_summary
);

   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        active_ff, active_in;
   logic [7:0]  id_ff, id_in;
   logic [31:0] ts_ff, ts_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  crc_high_ff, crc_high_in;

   logic        req_accept;
   logic [8:0]  pos_cur;
   logic [15:0] crc_cur;
   logic        active_cur;
   logic [8:0]  crc_pos;
   logic        push_valid;
   logic        push_ready;
   crcpd_pkg::result_type push_data;
   crcpd_pkg::result_type pop_data;

   assign req_tready = push_ready;
   assign req_accept = req_tvalid && req_tready;
   assign crc_pos    = crcpd_pkg::HEADER_BYTES + {1'b0, len_ff};

   // Decode one byte against the frame state
   always_comb begin
      pos_cur    = req_tuser ? 9'd0 : pos_ff;
      crc_cur    = req_tuser ? crcpd_pkg::CRC_INIT : crc_ff;
      active_cur = req_tuser || active_ff;

      pos_in      = pos_ff;
      crc_in      = crc_ff;
      active_in   = active_ff;
      id_in       = id_ff;
      ts_in       = ts_ff;
      len_in      = len_ff;
      crc_high_in = crc_high_ff;

      push_valid                = 1'b0;
      push_data.is_summary      = 1'b0;
      push_data.crc_ok          = 1'b0;
      push_data.payload_byte    = req_tdata;
      push_data.payload_index   = pos_cur[7:0] - crcpd_pkg::HEADER_BYTES[7:0];
      push_data.frame_id        = id_ff;
      push_data.frame_timestamp = ts_ff;
      push_data.payload_length  = len_ff;

      if (req_accept && active_cur) begin
         pos_in    = pos_cur + 9'd1;
         crc_in    = crc_cur;
         active_in = 1'b1;
         priority if (pos_cur < crcpd_pkg::HEADER_BYTES) begin
            crc_in = crcpd_pkg::crc_feed(crc_cur, req_tdata);
            if (pos_cur == crcpd_pkg::POS_ID) begin
               id_in = req_tdata;
            end else if (pos_cur >= crcpd_pkg::POS_TS_FIRST &&
                         pos_cur <= crcpd_pkg::POS_TS_LAST) begin
               ts_in = {ts_ff[23:0], req_tdata};
            end else if (pos_cur == crcpd_pkg::POS_LENGTH) begin
               len_in = req_tdata;
            end
         end else if (pos_cur < crc_pos) begin
            // Payload byte is pushed to the queue at once
            crc_in     = crcpd_pkg::crc_feed(crc_cur, req_tdata);
            push_valid = 1'b1;
         end else if (pos_cur == crc_pos) begin
            crc_high_in = req_tdata;
         end else begin
            // CRC low byte: summary, then idle
            push_valid              = 1'b1;
            push_data.is_summary    = 1'b1;
            push_data.payload_byte  = 8'd0;
            push_data.payload_index = 8'd0;
            push_data.crc_ok        = (crc_cur == {crc_high_ff, req_tdata});
            active_in               = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 9'd0;
         crc_ff      <= crcpd_pkg::CRC_INIT;
         active_ff   <= 1'b0;
         id_ff       <= 8'd0;
         ts_ff       <= 32'd0;
         len_ff      <= 8'd0;
         crc_high_ff <= 8'd0;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         active_ff   <= active_in;
         id_ff       <= id_in;
         ts_ff       <= ts_in;
         len_ff      <= len_in;
         crc_high_ff <= crc_high_in;
      end
   end

   crcpd_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (pop_data)
   );

   // Response packing
   assign rsp_tuser = pop_data.is_summary;
   assign rsp_tdata = {7'd0, pop_data.crc_ok, pop_data.payload_length,
                       pop_data.frame_timestamp, pop_data.frame_id,
                       pop_data.payload_index, pop_data.payload_byte};

   // Checks
   a_summary_idles: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_data.is_summary) |=> !active_ff)
      else $error("decoder still active after summary");
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (pop_data.payload_index < pop_data.payload_length))
      else $error("payload index beyond declared length");
   a_payload_no_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> !pop_data.crc_ok)
      else $error("crc_ok set on a payload response");
   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      (!active_ff && !req_tuser) |-> !push_valid)
      else $error("response from a byte outside a frame");

endmodule

FILE: sv/crcpd_out_queue.sv
// Two-entry result queue that decouples the decoder from a stalling receiver.
module crcpd_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  crcpd_pkg::result_type  push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output crcpd_pkg::result_type  pop_data
);

   crcpd_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("push without pop did not grow the queue");

endmodule
